[rtl/core/wmp_pkg.sv]
// Package for the weighted motion predictor: field widths and prediction limits.
// No dependencies.
`timescale 1ns / 1ps

package wmp_pkg;

    localparam int IN_W     = 12;
    localparam int CENTER_W = 12;
    localparam int PRED_W   = 14;
    localparam int COUNT_W  = 3;

    localparam int PRED_MIN = -8192;
    localparam int PRED_MAX = 8191;

    typedef logic [IN_W-1:0]          pix_t;
    typedef logic [CENTER_W-1:0]      center_t;
    typedef logic signed [PRED_W-1:0] pred_t;
    typedef logic [COUNT_W-1:0]       count_t;

endpackage

[rtl/core/weighted_motion_predictor_top.sv]
// Weighted motion predictor: box centre, centre history and rounded weighted-delta prediction.
// Depends on wmp_pkg for field widths and prediction limits.
//
//  channel | ports                                             | dir | handshake
//  --------+---------------------------------------------------+-----+----------------
//  input   | s_new_track s_box_left s_box_top s_box_width s_box_height | in  | s_valid/s_ready
//  result  | m_center_x m_center_y m_predicted_x m_predicted_y m_history_count | out | m_valid/m_ready
//
// A transaction runs from acceptance through the accumulate loop over the older centres and
// the restoring divider, one quotient bit a cycle, run once per axis, to the next s_ready.
// s_ready is high only while idle; a finished result waits in the output register and
// the next transaction is taken while it waits. Reset empties the history.
`timescale 1ns / 1ps

module weighted_motion_predictor_top
    import wmp_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5,
    parameter int COORD_BITS    = 12
) (
    input  logic    aclk,
    input  logic    aresetn,

    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_new_track,
    input  pix_t    s_box_left,
    input  pix_t    s_box_top,
    input  pix_t    s_box_width,
    input  pix_t    s_box_height,

    output logic    m_valid,
    input  logic    m_ready,
    output center_t m_center_x,
    output center_t m_center_y,
    output pred_t   m_predicted_x,
    output pred_t   m_predicted_y,
    output count_t  m_history_count
);

    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int IW     = $clog2(HISTORY_DEPTH);
    localparam int DIVMAX = HISTORY_DEPTH * (HISTORY_DEPTH - 1) / 2;
    localparam int DIVW   = $clog2(DIVMAX + 1);
    localparam int DENW   = DIVW + 1;
    localparam int MAGW   = COORD_BITS + CW;
    localparam int SUMW   = MAGW + 1;
    localparam int NUMW   = MAGW + 2;
    localparam int QW     = COORD_BITS;
    localparam int QCW    = $clog2(QW);
    localparam int DSW    = DENW + QW;
    localparam int REMW   = (NUMW > DSW) ? NUMW : DSW;
    localparam int PW     = COORD_BITS + 2;
    localparam int EW     = (PW > PRED_W + 1) ? PW : PRED_W + 1;
    localparam int CXW    = (COORD_BITS > IN_W + 1) ? COORD_BITS : IN_W + 1;

    localparam logic [CXW-1:0]       COORD_MAX = CXW'((1 << COORD_BITS) - 1);
    localparam logic signed [EW-1:0] PMIN_E    = EW'(PRED_MIN);
    localparam logic signed [EW-1:0] PMAX_E    = EW'(PRED_MAX);
    localparam logic [CW-1:0]        DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam logic [CW-1:0]        ONE_C     = CW'(1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;

    logic [COORD_BITS-1:0]  hist_x_reg [HISTORY_DEPTH];
    logic [COORD_BITS-1:0]  hist_x_next[HISTORY_DEPTH];
    logic [COORD_BITS-1:0]  hist_y_reg [HISTORY_DEPTH];
    logic [COORD_BITS-1:0]  hist_y_next[HISTORY_DEPTH];
    logic [COORD_BITS-1:0]  last_x_reg, last_x_next;
    logic [COORD_BITS-1:0]  last_y_reg, last_y_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic signed [SUMW-1:0] acc_x_reg, acc_x_next;
    logic signed [SUMW-1:0] acc_y_reg, acc_y_next;
    logic [DIVW-1:0]        div_reg, div_next;
    logic                   axis_reg, axis_next;
    logic                   neg_reg, neg_next;
    logic [REMW-1:0]        rem_reg, rem_next;
    logic [REMW-1:0]        den_reg, den_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic [QCW-1:0]         iter_reg, iter_next;
    pred_t                  pred_x_reg, pred_x_next;
    pred_t                  pred_y_reg, pred_y_next;
    center_t                out_cx_reg, out_cx_next;
    center_t                out_cy_reg, out_cy_next;
    pred_t                  out_px_reg, out_px_next;
    pred_t                  out_py_reg, out_py_next;
    count_t                 out_cnt_reg, out_cnt_next;

    // Centre of the incoming box, saturated
    logic [CXW-1:0]         cx_wide, cy_wide, cx_sat, cy_sat;
    logic [CW-1:0]          cnt_base, n_new;
    logic signed [SUMW-1:0] acc_sel, acc_abs;
    logic [MAGW-1:0]        mag;
    logic [NUMW-1:0]        num;
    logic                   rem_ge;
    logic signed [PW-1:0]   delta, pred_sum;
    logic signed [EW-1:0]   pred_ext;
    pred_t                  pred_sat;

    assign cx_wide = CXW'(s_box_left) + CXW'(s_box_width[IN_W-1:1]);
    assign cy_wide = CXW'(s_box_top) + CXW'(s_box_height[IN_W-1:1]);
    assign cx_sat  = (cx_wide > COORD_MAX) ? COORD_MAX : cx_wide;
    assign cy_sat  = (cy_wide > COORD_MAX) ? COORD_MAX : cy_wide;

    assign cnt_base = s_new_track ? '0 : count_reg;
    assign n_new    = (cnt_base == DEPTH_C) ? DEPTH_C : cnt_base + ONE_C;

    // Shared divider front end and result stage
    assign acc_sel = axis_reg ? acc_y_reg : acc_x_reg;
    assign acc_abs = acc_sel[SUMW-1] ? -acc_sel : acc_sel;
    assign mag     = acc_abs[MAGW-1:0];
    assign num     = {1'b0, mag, 1'b0} + NUMW'(div_reg);
    assign rem_ge  = (rem_reg >= den_reg);

    assign delta    = (div_reg == '0) ? '0
                    : (neg_reg ? -$signed(PW'(quo_reg)) : $signed(PW'(quo_reg)));
    assign pred_sum = $signed(PW'(axis_reg ? last_y_reg : last_x_reg)) + delta;
    assign pred_ext = EW'(pred_sum);
    assign pred_sat = (pred_ext < PMIN_E) ? PMIN_E[PRED_W-1:0]
                    : (pred_ext > PMAX_E) ? PMAX_E[PRED_W-1:0]
                    : pred_ext[PRED_W-1:0];

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        hist_x_next  = hist_x_reg;
        hist_y_next  = hist_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        idx_next     = idx_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        div_next     = div_reg;
        axis_next    = axis_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        iter_next    = iter_reg;
        pred_x_next  = pred_x_reg;
        pred_y_next  = pred_y_reg;
        out_cx_next  = out_cx_reg;
        out_cy_next  = out_cy_reg;
        out_px_next  = out_px_reg;
        out_py_next  = out_py_reg;
        out_cnt_next = out_cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (cnt_base == DEPTH_C) begin
                        // drop the oldest centre
                        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                            hist_x_next[i] = hist_x_reg[i+1];
                            hist_y_next[i] = hist_y_reg[i+1];
                        end
                        hist_x_next[HISTORY_DEPTH-1] = cx_sat[COORD_BITS-1:0];
                        hist_y_next[HISTORY_DEPTH-1] = cy_sat[COORD_BITS-1:0];
                    end else begin
                        hist_x_next[cnt_base[IW-1:0]] = cx_sat[COORD_BITS-1:0];
                        hist_y_next[cnt_base[IW-1:0]] = cy_sat[COORD_BITS-1:0];
                    end
                    count_next  = n_new;
                    last_x_next = cx_sat[COORD_BITS-1:0];
                    last_y_next = cy_sat[COORD_BITS-1:0];
                    idx_next    = '0;
                    acc_x_next  = '0;
                    acc_y_next  = '0;
                    div_next    = '0;
                    axis_next   = 1'b0;
                    state_next  = (n_new == ONE_C) ? ST_PREP : ST_ACC;
                end
            end
            ST_ACC: begin
                // sum of k*delta telescopes to the sum of (last - older centre)
                acc_x_next = acc_x_reg + ($signed(SUMW'(last_x_reg))
                                        - $signed(SUMW'(hist_x_reg[idx_reg])));
                acc_y_next = acc_y_reg + ($signed(SUMW'(last_y_reg))
                                        - $signed(SUMW'(hist_y_reg[idx_reg])));
                div_next   = div_reg + DIVW'(idx_reg) + DIVW'(1);
                idx_next   = idx_reg + IW'(1);
                if (CW'(idx_reg) + ONE_C == count_reg - ONE_C) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                neg_next   = acc_sel[SUMW-1];
                rem_next   = REMW'(num);
                den_next   = REMW'({div_reg, 1'b0}) << (QW - 1);
                quo_next   = '0;
                iter_next  = QCW'(QW - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (rem_ge) begin
                    rem_next = rem_reg - den_reg;
                end
                quo_next = {quo_reg[QW-2:0], rem_ge};
                den_next = den_reg >> 1;
                if (iter_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    iter_next = iter_reg - QCW'(1);
                end
            end
            ST_FIN: begin
                if (axis_reg) begin
                    pred_y_next = pred_sat;
                    state_next  = ST_DONE;
                end else begin
                    pred_x_next = pred_sat;
                    axis_next   = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_cx_next  = CENTER_W'(last_x_reg);
                    out_cy_next  = CENTER_W'(last_y_reg);
                    out_px_next  = pred_x_reg;
                    out_py_next  = pred_y_reg;
                    out_cnt_next = COUNT_W'(count_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hist_x_reg  <= hist_x_next;
        hist_y_reg  <= hist_y_next;
        last_x_reg  <= last_x_next;
        last_y_reg  <= last_y_next;
        idx_reg     <= idx_next;
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        div_reg     <= div_next;
        axis_reg    <= axis_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        quo_reg     <= quo_next;
        iter_reg    <= iter_next;
        pred_x_reg  <= pred_x_next;
        pred_y_reg  <= pred_y_next;
        out_cx_reg  <= out_cx_next;
        out_cy_reg  <= out_cy_next;
        out_px_reg  <= out_px_next;
        out_py_reg  <= out_py_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_center_x      = out_cx_reg;
    assign m_center_y      = out_cy_reg;
    assign m_predicted_x   = out_px_reg;
    assign m_predicted_y   = out_py_reg;
    assign m_history_count = out_cnt_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("history count above depth");

    a_count_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> count_reg != '0)
        else $error("history empty after a transaction");

    a_acc_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACC |-> count_reg >= CW'(2))
        else $error("accumulate entered with fewer than two centres");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion state");

endmodule
